// ===== hw/rtl/wtv_pkg.sv =====
// Shared types, constants and widths for the windowed trend/volatility classifier.
package wtv_pkg;

  localparam int WINDOW     = 100;
  localparam int PRICE_BITS = 24;

  localparam int ADDR_W     = $clog2(WINDOW);
  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int SUM_W      = PRICE_BITS + $clog2(WINDOW);
  localparam int SQ_W       = 2 * PRICE_BITS + $clog2(WINDOW);
  localparam int PROD_W     = FILL_W + SQ_W;
  localparam int FACTOR_W   = 4;
  localparam int KSQ_W      = 2 * FACTOR_W;
  localparam int RHS_W      = PROD_W + KSQ_W;
  localparam int CFG_W      = 7;
  localparam int PCT_W      = 7;
  localparam int PCT_PROD_W = SUM_W + PCT_W;
  localparam int PHASE_W    = 2;

  localparam int IN_TDATA_W  = ((PRICE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PHASE_W + FILL_W + 7) / 8) * 8;

  localparam logic [PCT_W-1:0] PCT_SCALE = PCT_W'(100);

  localparam logic [CFG_W-1:0]    TREND_MIN_RST    = CFG_W'(20);
  localparam logic [CFG_W-1:0]    CHAOS_MIN_RST    = CFG_W'(10);
  localparam logic [CFG_W-1:0]    TREND_PCT_RST    = CFG_W'(30);
  localparam logic [FACTOR_W-1:0] CHAOS_FACTOR_RST = FACTOR_W'(2);

  typedef enum logic [1:0] {
    REG_TREND_MIN    = 2'd0,
    REG_CHAOS_MIN    = 2'd1,
    REG_TREND_PCT    = 2'd2,
    REG_CHAOS_FACTOR = 2'd3
  } wtv_reg_t;

  typedef enum logic [PHASE_W-1:0] {
    PHASE_RANGING  = 2'd0,
    PHASE_TRENDING = 2'd1,
    PHASE_CHAOS    = 2'd2
  } wtv_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_A,
    ST_READ_B,
    ST_PREP,
    ST_MUL,
    ST_SCALE,
    ST_OUT
  } wtv_state_t;

  // one strobe per sequencer step up to the scale step; the output step has none
  typedef struct packed {
    logic load;
    logic take_a;
    logic commit;
    logic prep;
    logic mul;
    logic scale;
  } wtv_ctrl_t;

  typedef struct packed {
    logic [CFG_W-1:0]    trend_min;
    logic [CFG_W-1:0]    chaos_min;
    logic [PCT_W-1:0]    trend_pct;
    logic [FACTOR_W-1:0] chaos_factor;
  } wtv_cfg_t;

endpackage

// ===== hw/rtl/windowed_trend_volatility_classifier_top.sv =====
// Windowed trend/volatility classifier: sequencer, configuration and output register.
// One price per transfer in, one phase result per price out. The input is ready again once
// the result is loaded into the output register, so no new price is taken before the last
// one is through. The sequencer makes two reads through the ring memory's single read port
// (oldest price and its successor), commits the sums and the ring write, then runs three
// register-separated multiply steps (n*Q and S^2, moves^2 and the percent products,
// factor^2 times variance) before the compare. The output register lets a new price be
// taken while the previous result waits; a result that is held back by the sink stalls the
// sequencer in its last step. Write configuration only while no item is in flight; writes
// are not held off by the sequencer.
module windowed_trend_volatility_classifier_top (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata: price
  input  logic [wtv_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // m_tdata: phase, window_fill
  output logic [wtv_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_addr,
  input  logic [wtv_pkg::CFG_W-1:0]       cfg_data
);
  import wtv_pkg::*;

  wtv_state_t            state;
  wtv_state_t            state_next;
  wtv_ctrl_t             ctrl;
  wtv_cfg_t              cfg;
  logic                  out_load;

  logic [PRICE_BITS-1:0] price;
  logic [PRICE_BITS-1:0] price_held;
  logic [PRICE_BITS-1:0] rd_data;
  logic [FILL_W-1:0]     fill;
  logic                  full;
  wtv_phase_t            phase;

  logic [PHASE_W-1:0]    out_phase;
  logic [FILL_W-1:0]     out_fill;

  assign price = s_tdata[PRICE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trend_min    <= TREND_MIN_RST;
      cfg.chaos_min    <= CHAOS_MIN_RST;
      cfg.trend_pct    <= TREND_PCT_RST;
      cfg.chaos_factor <= CHAOS_FACTOR_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TREND_MIN:    cfg.trend_min    <= cfg_data;
        REG_CHAOS_MIN:    cfg.chaos_min    <= cfg_data;
        REG_TREND_PCT:    cfg.trend_pct    <= cfg_data;
        REG_CHAOS_FACTOR: cfg.chaos_factor <= cfg_data[FACTOR_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        ctrl.load = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_READ_A;
        end
      end
      ST_READ_A: begin
        ctrl.take_a = 1'b1;
        state_next  = ST_READ_B;
      end
      ST_READ_B: begin
        ctrl.commit = 1'b1;
        state_next  = ST_PREP;
      end
      ST_PREP: begin
        ctrl.prep  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        ctrl.mul   = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        ctrl.scale = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  wtv_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .wr_data (price_held),
    .rd_data (rd_data),
    .fill    (fill),
    .full    (full)
  );

  wtv_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cfg        (cfg),
    .price      (price),
    .rd_data    (rd_data),
    .fill       (fill),
    .full       (full),
    .price_held (price_held),
    .phase      (phase)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_phase <= phase;
      out_fill  <= fill;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - PHASE_W - FILL_W)'(0), out_fill, out_phase};

endmodule

// ===== hw/rtl/wtv_ring.sv =====
// Price ring memory with oldest pointer and fill count.
module wtv_ring (
  input  logic                           clk,
  input  logic                           rst,
  input  wtv_pkg::wtv_ctrl_t             ctrl,
  input  logic [wtv_pkg::PRICE_BITS-1:0] wr_data,
  output logic [wtv_pkg::PRICE_BITS-1:0] rd_data,
  output logic [wtv_pkg::FILL_W-1:0]     fill,
  output logic                           full
);
  import wtv_pkg::*;

  logic [PRICE_BITS-1:0] mem [WINDOW];
  logic [ADDR_W-1:0]     oldest;
  logic [ADDR_W-1:0]     oldest_next;
  logic [ADDR_W:0]       tail_sum;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  rd_en;

  assign full        = (fill == FILL_W'(WINDOW));
  assign oldest_next = (oldest == ADDR_W'(WINDOW - 1)) ? '0 : oldest + 1'b1;
  assign tail_sum    = {1'b0, oldest} + (ADDR_W + 1)'(fill);

  always_comb begin
    if (full) begin
      wr_addr = oldest;
    end else if (tail_sum >= (ADDR_W + 1)'(WINDOW)) begin
      wr_addr = ADDR_W'(tail_sum - (ADDR_W + 1)'(WINDOW));
    end else begin
      wr_addr = tail_sum[ADDR_W-1:0];
    end
  end

  // oldest entry on load, its successor on the next step
  assign rd_addr = ctrl.take_a ? oldest_next : oldest;
  assign rd_en   = ctrl.load | ctrl.take_a;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (ctrl.commit) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      fill   <= '0;
    end else if (ctrl.commit) begin
      if (full) begin
        oldest <= oldest_next;
      end else begin
        fill <= fill + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/wtv_core.sv =====
// Running sums, variance and move products, and the phase decision.
module wtv_core (
  input  logic                           clk,
  input  logic                           rst,
  input  wtv_pkg::wtv_ctrl_t             ctrl,
  input  wtv_pkg::wtv_cfg_t              cfg,
  input  logic [wtv_pkg::PRICE_BITS-1:0] price,
  input  logic [wtv_pkg::PRICE_BITS-1:0] rd_data,
  input  logic [wtv_pkg::FILL_W-1:0]     fill,
  input  logic                           full,
  output logic [wtv_pkg::PRICE_BITS-1:0] price_held,
  output wtv_pkg::wtv_phase_t            phase
);
  import wtv_pkg::*;

  logic [PRICE_BITS-1:0]   newest;
  logic [SUM_W-1:0]        sum_up;
  logic [SUM_W-1:0]        sum_down;
  logic [SUM_W-1:0]        sum_p;
  logic [SQ_W-1:0]         sum_sq;

  logic [2*PRICE_BITS-1:0] p_sq;
  logic [PRICE_BITS-1:0]   a_val;
  logic [2*PRICE_BITS-1:0] a_sq;
  logic [SUM_W-1:0]        moves;
  logic [SUM_W-1:0]        diff;
  logic [KSQ_W-1:0]        k_sq;
  logic [PROD_W-1:0]       nq;
  logic [PROD_W-1:0]       ss;
  logic [PROD_W-1:0]       mm;
  logic [PROD_W-1:0]       var_v;
  logic [PCT_PROD_W-1:0]   diff_pct;
  logic [PCT_PROD_W-1:0]   moves_pct;
  logic [RHS_W-1:0]        rhs;

  logic [SUM_W-1:0]        a_out;
  logic [SQ_W-1:0]         a_sq_out;
  logic                    chaos;
  logic                    trending;

  assign a_out    = full ? SUM_W'(a_val) : '0;
  assign a_sq_out = full ? SQ_W'(a_sq) : '0;

  // running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      newest   <= '0;
      sum_up   <= '0;
      sum_down <= '0;
      sum_p    <= '0;
      sum_sq   <= '0;
    end else begin
      if (ctrl.load && fill != '0) begin
        if (price >= newest) begin
          sum_up <= sum_up + SUM_W'(price - newest);
        end else begin
          sum_down <= sum_down + SUM_W'(newest - price);
        end
      end
      if (ctrl.commit) begin
        // evict the move from the oldest price to its successor
        if (full) begin
          if (rd_data >= a_val) begin
            sum_up <= sum_up - SUM_W'(rd_data - a_val);
          end else begin
            sum_down <= sum_down - SUM_W'(a_val - rd_data);
          end
        end
        sum_p  <= sum_p + SUM_W'(price_held) - a_out;
        sum_sq <= sum_sq + SQ_W'(p_sq) - a_sq_out;
        newest <= price_held;
      end
    end
  end

  // datapath registers, one multiplier per path
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      price_held <= price;
      p_sq       <= price * price;
    end
    if (ctrl.take_a) begin
      a_val <= rd_data;
      a_sq  <= rd_data * rd_data;
    end
    if (ctrl.prep) begin
      moves <= sum_up + sum_down;
      diff  <= (sum_up >= sum_down) ? sum_up - sum_down : sum_down - sum_up;
      k_sq  <= cfg.chaos_factor * cfg.chaos_factor;
      nq    <= PROD_W'(fill) * PROD_W'(sum_sq);
      ss    <= PROD_W'(sum_p) * PROD_W'(sum_p);
    end
    if (ctrl.mul) begin
      mm        <= PROD_W'(moves) * PROD_W'(moves);
      diff_pct  <= PCT_PROD_W'(diff) * PCT_PROD_W'(PCT_SCALE);
      moves_pct <= PCT_PROD_W'(moves) * PCT_PROD_W'(cfg.trend_pct);
      var_v     <= (nq >= ss) ? nq - ss : '0;
    end
    if (ctrl.scale) begin
      rhs <= RHS_W'(var_v) * RHS_W'(k_sq);
    end
  end

  assign chaos    = (fill >= FILL_W'(cfg.chaos_min)) && (RHS_W'(mm) > rhs);
  assign trending = (fill >= FILL_W'(cfg.trend_min)) && (diff_pct > moves_pct);

  always_comb begin
    if (chaos) begin
      phase = PHASE_CHAOS;
    end else if (trending) begin
      phase = PHASE_TRENDING;
    end else begin
      phase = PHASE_RANGING;
    end
  end

endmodule

// ===== hw/rtl/wtv_checker.sv =====
// Port-level checks for the classifier top level, and their bind.
module wtv_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [wtv_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready
);
  import wtv_pkg::*;

  logic [PHASE_W-1:0] out_phase;
  logic [FILL_W-1:0]  out_fill;

  assign out_phase = m_tdata[PHASE_W-1:0];
  assign out_fill  = m_tdata[PHASE_W+FILL_W-1:PHASE_W];

  // one price in flight: no input transfer straight after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in flight");

  // a new result only appears as the sequencer finishes an item
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without an item in flight");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_fill != '0) && (out_fill <= FILL_W'(WINDOW)))
    else $error("window fill out of range");

  a_phase_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_phase == PHASE_RANGING) || (out_phase == PHASE_TRENDING) ||
                 (out_phase == PHASE_CHAOS))
    else $error("undefined phase code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind windowed_trend_volatility_classifier_top wtv_checker u_wtv_checker (.*);

// ===== dv/windowed_trend_volatility_classifier_top_test.sv =====
// Self-checking testbench for the windowed trend/volatility classifier top level.
`timescale 1ns / 100ps

module windowed_trend_volatility_classifier_top_test;
  import wtv_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PAD_W       = OUT_TDATA_W - PHASE_W - FILL_W;
  localparam logic [23:0] PRICE_MAX = 24'hFFFFFF;

  typedef struct packed {
    wtv_phase_t        phase;
    logic [FILL_W-1:0] fill;
  } phase_result_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic                  typed;
    wtv_phase_t            phase;
    logic [FILL_W-1:0]     fill;
  } probe_row_t;

  typedef enum int {
    SEG_FLAT,
    SEG_RISE,
    SEG_FALL,
    SEG_WALK,
    SEG_NOISE,
    SEG_SWING
  } segment_kind_t;

  logic                   clk;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic                   cfg_we;
  logic [1:0]             cfg_addr;
  logic [CFG_W-1:0]       cfg_data;

  // typed expectation travelling with the price on offer
  logic                   tag_typed;
  wtv_phase_t             tag_phase;
  logic [FILL_W-1:0]      tag_fill;

  int src_gap_pct  = 32;
  int sink_idle_pct = 32;
  int sink_hold    = 0;
  int hold_request = 0;
  int fail_count   = 0;

  phase_result_t pending_phases [$];

  // predictor state
  logic [PRICE_BITS-1:0] price_hist [WINDOW];
  int                    hist_head;
  int                    hist_fill;
  logic [PRICE_BITS-1:0] last_price;
  logic [63:0]           rise_total;
  logic [63:0]           fall_total;
  logic [63:0]           price_total;
  logic [63:0]           square_total;
  wtv_cfg_t              cfg_shadow;

  probe_row_t probes [0:23];

  windowed_trend_volatility_classifier_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),   // price
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),   // phase, window_fill, zero pad
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Advances the window by one price and classifies what it then holds.
  function automatic phase_result_t classify_price(input logic [PRICE_BITS-1:0] p);
    int            op;
    int            nx;
    logic [23:0]   a;
    logic [23:0]   b;
    logic [127:0]  nq;
    logic [127:0]  ss;
    logic [127:0]  spread;
    logic [127:0]  moves;
    logic [127:0]  diff;
    logic [127:0]  k2;
    phase_result_t r;
    if (hist_fill > 0) begin
      if (p >= last_price) rise_total += 64'(p) - 64'(last_price);
      else fall_total += 64'(last_price) - 64'(p);
    end
    if (hist_fill >= WINDOW) begin
      // evict the oldest price and the move that follows it
      op = hist_head;
      nx = (op + 1) % WINDOW;
      a  = price_hist[op];
      b  = price_hist[nx];
      if (b >= a) rise_total -= 64'(b) - 64'(a);
      else fall_total -= 64'(a) - 64'(b);
      price_total  -= 64'(a);
      square_total -= 64'(a) * 64'(a);
      price_hist[op] = p;
      hist_head = nx;
    end else begin
      price_hist[(hist_head + hist_fill) % WINDOW] = p;
      hist_fill++;
    end
    last_price    = p;
    price_total  += 64'(p);
    square_total += 64'(p) * 64'(p);

    nq     = 128'(hist_fill) * 128'(square_total);
    ss     = 128'(price_total) * 128'(price_total);
    spread = (ss > nq) ? 128'd0 : nq - ss;
    moves  = 128'(rise_total) + 128'(fall_total);
    diff   = (rise_total >= fall_total) ? 128'(rise_total - fall_total)
                                        : 128'(fall_total - rise_total);
    k2     = 128'(cfg_shadow.chaos_factor) * 128'(cfg_shadow.chaos_factor);

    r.fill = FILL_W'(hist_fill);
    if (hist_fill >= cfg_shadow.chaos_min && moves * moves > spread * k2)
      r.phase = PHASE_CHAOS;
    else if (hist_fill >= cfg_shadow.trend_min &&
             diff * 128'd100 > moves * 128'(cfg_shadow.trend_pct))
      r.phase = PHASE_TRENDING;
    else
      r.phase = PHASE_RANGING;
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    phase_result_t want;
    phase_result_t got;
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) price_hist[i] = '0;
      hist_head    = 0;
      hist_fill    = 0;
      last_price   = '0;
      rise_total   = '0;
      fall_total   = '0;
      price_total  = '0;
      square_total = '0;
      cfg_shadow   = '{TREND_MIN_RST, CHAOS_MIN_RST, TREND_PCT_RST, CHAOS_FACTOR_RST};
      pending_phases.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.phase = wtv_phase_t'(m_tdata[PHASE_W-1:0]);
        got.fill  = m_tdata[PHASE_W +: FILL_W];
        if (pending_phases.size() == 0) begin
          note_failure($sformatf("unexpected result: phase %0d fill %0d",
                                 got.phase, got.fill));
        end else begin
          want = pending_phases.pop_front();
          if (m_tdata !== {{PAD_W{1'b0}}, want.fill, want.phase})
            note_failure($sformatf(
              "mismatch: phase exp %0d got %0d, fill exp %0d got %0d, tdata %h",
              want.phase, got.phase, want.fill, got.fill, m_tdata));
        end
      end
      if (s_tvalid && s_tready) begin
        want = classify_price(s_tdata[PRICE_BITS-1:0]);
        if (tag_typed) begin
          want.phase = tag_phase;
          want.fill  = tag_fill;
        end
        pending_phases.insert(pending_phases.size(), want);
      end
      if (cfg_we) begin
        case (wtv_reg_t'(cfg_addr))
          REG_TREND_MIN:    cfg_shadow.trend_min    = cfg_data;
          REG_CHAOS_MIN:    cfg_shadow.chaos_min    = cfg_data;
          REG_TREND_PCT:    cfg_shadow.trend_pct    = cfg_data;
          REG_CHAOS_FACTOR: cfg_shadow.chaos_factor = cfg_data[FACTOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // sink: random back-pressure, plus a long hold-off when asked
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        m_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("windowed_trend_volatility_classifier_top regression: fail");
    $finish;
  end

  task automatic send_price(input logic [PRICE_BITS-1:0] p, input logic typed,
                            input wtv_phase_t phase, input logic [FILL_W-1:0] fill);
    while (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= IN_TDATA_W'(p);
    tag_typed <= typed;
    tag_phase <= phase;
    tag_fill  <= fill;
    do @(posedge clk); while (!s_tready);
  endtask

  // wait for every result, then let the sequencer settle before touching registers
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_phases.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input logic [CFG_W-1:0] tmin,
                           input logic [CFG_W-1:0] cmin, input logic [CFG_W-1:0] pct,
                           input logic [CFG_W-1:0] factor);
    int            left;
    int            seg;
    int            step;
    segment_kind_t kind;
    longint        q;
    logic [23:0]   walk;
    drain_results();
    cfg_we   <= 1'b1;
    cfg_addr <= REG_TREND_MIN;
    cfg_data <= tmin;
    @(posedge clk);
    cfg_addr <= REG_CHAOS_MIN;
    cfg_data <= cmin;
    @(posedge clk);
    cfg_addr <= REG_TREND_PCT;
    cfg_data <= pct;
    @(posedge clk);
    cfg_addr <= REG_CHAOS_FACTOR;
    cfg_data <= factor;
    @(posedge clk);
    cfg_we <= 1'b0;
    // hold-off starts with the first price of this run
    sink_hold    = hold_request;
    hold_request = 0;

    left = count;
    walk = 24'($urandom & PRICE_MAX);
    while (left > 0) begin
      seg  = $urandom_range(4, 40);
      kind = segment_kind_t'($urandom_range(0, 5));
      step = $urandom_range(1, 1 << $urandom_range(0, 16));
      for (int i = 0; i < seg && left > 0; i++) begin
        q = longint'(walk);
        case (kind)
          SEG_FLAT:  ;
          SEG_RISE:  q = q + step + longint'($urandom_range(0, step)) - step / 2;
          SEG_FALL:  q = q - step - longint'($urandom_range(0, step)) + step / 2;
          SEG_WALK:  q = q + longint'($urandom_range(0, 2 * step)) - step;
          SEG_NOISE: q = longint'($urandom & PRICE_MAX);
          SEG_SWING: q = (i % 2 == 0) ? q + step : q - step;
          default: ;
        endcase
        if (q < 0) q = 0;
        if (q > longint'(PRICE_MAX)) q = longint'(PRICE_MAX);
        walk = 24'(q);
        send_price(walk, 1'b0, PHASE_RANGING, '0);
        left--;
      end
    end
  endtask

  initial begin
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    tag_typed <= 1'b0;
    tag_phase <= PHASE_RANGING;
    tag_fill  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_TREND_MIN;
    cfg_data  <= '0;
    rst       <= 1'b1;

    // Below the reset chaos minimum everything is ranging, whatever the moves.
    probes = '{
      '{24'h000000, 1'b1, PHASE_RANGING, 7'd1},   // empty window, no move yet
      '{24'h000000, 1'b1, PHASE_RANGING, 7'd2},   // flat
      '{24'h000000, 1'b1, PHASE_RANGING, 7'd3},
      '{24'hFFFFFF, 1'b1, PHASE_RANGING, 7'd4},   // full-scale up move
      '{24'h000000, 1'b1, PHASE_RANGING, 7'd5},   // full-scale down move
      '{24'hFFFFFF, 1'b1, PHASE_RANGING, 7'd6},
      '{24'h000000, 1'b1, PHASE_RANGING, 7'd7},
      '{24'hFFFFFF, 1'b1, PHASE_RANGING, 7'd8},
      '{24'h000001, 1'b1, PHASE_RANGING, 7'd9},
      '{24'hFFFFFF, 1'b0, PHASE_RANGING, 7'd0},   // chaos minimum reached
      '{24'h000000, 1'b0, PHASE_RANGING, 7'd0},
      '{24'hFFFFFE, 1'b0, PHASE_RANGING, 7'd0},
      '{24'h800000, 1'b0, PHASE_RANGING, 7'd0},
      '{24'h800100, 1'b0, PHASE_RANGING, 7'd0},   // steady rise
      '{24'h800200, 1'b0, PHASE_RANGING, 7'd0},
      '{24'h800300, 1'b0, PHASE_RANGING, 7'd0},
      '{24'h800400, 1'b0, PHASE_RANGING, 7'd0},
      '{24'h800500, 1'b0, PHASE_RANGING, 7'd0},
      '{24'h800600, 1'b0, PHASE_RANGING, 7'd0},
      '{24'h800700, 1'b0, PHASE_RANGING, 7'd0},   // trend minimum reached
      '{24'h800800, 1'b0, PHASE_RANGING, 7'd0},
      '{24'h800900, 1'b0, PHASE_RANGING, 7'd0},
      '{24'h800A00, 1'b0, PHASE_RANGING, 7'd0},
      '{24'h7FFF00, 1'b0, PHASE_RANGING, 7'd0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i])
      send_price(probes[i].price, probes[i].typed, probes[i].phase, probes[i].fill);

    run_phase(50, 7'd20, 7'd10, 7'd30, 7'd2);
    run_phase(50, 7'd2, 7'd2, 7'd0, 7'd15);
    run_phase(50, 7'd100, 7'd100, 7'd100, 7'd1);
    // out of range: minima always met, factor written as zero through its upper bits
    run_phase(50, 7'd0, 7'd1, 7'd127, 7'h70);
    run_phase(50, 7'd127, 7'd127, 7'd101, 7'h7F);

    // back-to-back stretch with no idling on either side
    src_gap_pct   = 0;
    sink_idle_pct = 0;
    run_phase(50, 7'd10, 7'd5, 7'd20, 7'd1);

    // sink holds off while the source keeps offering, so the input stalls
    hold_request = 150;
    run_phase(50, 7'd3, 7'd50, 7'd10, 7'd1);
    src_gap_pct   = 32;
    sink_idle_pct = 32;

    repeat (3)
      run_phase(50, 7'($urandom_range(2, 100)), 7'($urandom_range(2, 100)),
                7'($urandom_range(0, 100)), 7'($urandom_range(1, 15)));

    s_tvalid <= 1'b0;
    while (pending_phases.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_phases.size() == 0)
      $display("windowed_trend_volatility_classifier_top regression: pass");
    else
      $display("windowed_trend_volatility_classifier_top regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/wtv_pkg.sv
hw/rtl/wtv_ring.sv
hw/rtl/wtv_core.sv
hw/rtl/windowed_trend_volatility_classifier_top.sv
hw/rtl/wtv_checker.sv
dv/windowed_trend_volatility_classifier_top_test.sv
